@@ hdl/ipv4dq_pkg.sv @@
// Package for the dotted-quad IPv4 string parser.
// Holds the transfer payload types and the character constants.
// No dependencies.
package ipv4dq_pkg;

    localparam logic [9:0] C_OCTET_MAX   = 10'd255;
    localparam logic [7:0] C_DOT_CHAR    = 8'h2E;
    localparam logic [7:0] C_ZERO_CHAR   = 8'h30;
    localparam logic [7:0] C_NINE_CHAR   = C_ZERO_CHAR + 8'd9;
    localparam logic [1:0] C_LAST_OCTET  = 2'd3;  // octet count of four, less one

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last;
        logic       empty_string;
    } t_in_item;

    typedef struct packed {
        logic [31:0] address;
        logic        valid_res;
    } t_out_item;

endpackage

@@ hdl/ipv4_dotted_quad_parser_unit.sv @@
// Dotted-quad IPv4 string parser, top level.
// Depends on ipv4dq_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one string byte
//   per transfer; last marks the final byte, empty_string stands for a whole
//   zero-length string. Output channel (o_out_valid / i_out_ready /
//   o_out_data) gives one result per finished string: the packed address
//   (first octet in bits 31..24) and valid_res. Invalid strings give address 0.
//   An empty_string item drops any partial string and gives an invalid result.
//   A byte is registered in the input register on its input transfer, its
//   parse step runs from there, and the result is registered in the output
//   register, from which it is offered. Throughput: one byte per cycle while
//   the receiver does not stall, set by the parse-state update.
//   When the receiver stalls, the result is held in the output register and
//   one further byte waits in the input register; bytes that end no string
//   keep flowing, a byte that would give a second result waits.
//   Reset (synchronous, active low) clears both channels and the parse state.
module ipv4_dotted_quad_parser_unit
    import ipv4dq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [1:0]  r_octet_index, s_octet_index;
    logic [1:0]  r_digit_count, s_digit_count;
    logic [9:0]  r_octet_value, s_octet_value;
    logic        r_zero_closed, s_zero_closed;
    logic        r_failed,      s_failed;
    logic [23:0] r_addr,        s_addr;

    logic        is_digit;
    logic [3:0]  digit;
    logic        emits;
    logic        advance;
    logic        ok;
    t_out_item   n_out;

    assign is_digit = (r_in.char_byte >= C_ZERO_CHAR) && (r_in.char_byte <= C_NINE_CHAR);
    assign digit    = 4'(r_in.char_byte - C_ZERO_CHAR);
    assign emits    = r_in.last | r_in.empty_string;
    assign advance  = r_in_valid && (!emits || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // one byte of parse
    always_comb begin
        s_octet_index = r_octet_index;
        s_digit_count = r_digit_count;
        s_octet_value = r_octet_value;
        s_zero_closed = r_zero_closed;
        s_failed      = r_failed;
        s_addr        = r_addr;
        if (!r_failed) begin
            if (is_digit) begin
                if (r_zero_closed || r_digit_count == 2'd3) begin
                    s_failed = 1'b1;
                end else if (r_digit_count == 2'd0 && digit == 4'd0) begin
                    s_zero_closed = 1'b1;
                    s_digit_count = 2'd1;
                    s_octet_value = 10'd0;
                end else begin
                    s_octet_value = 10'(r_octet_value * 10'd10 + {6'd0, digit});
                    s_digit_count = r_digit_count + 2'd1;
                end
            end else if (r_in.char_byte == C_DOT_CHAR) begin
                if (r_digit_count == 2'd0 || r_octet_index == C_LAST_OCTET ||
                    r_octet_value > C_OCTET_MAX) begin
                    s_failed = 1'b1;
                end else begin
                    s_addr        = {r_addr[15:0], r_octet_value[7:0]};
                    s_octet_index = r_octet_index + 2'd1;
                    s_digit_count = 2'd0;
                    s_octet_value = 10'd0;
                    s_zero_closed = 1'b0;
                end
            end else begin
                s_failed = 1'b1;
            end
        end
    end

    always_comb begin
        ok = !s_failed && s_octet_index == C_LAST_OCTET && s_digit_count != 2'd0 &&
             s_octet_value <= C_OCTET_MAX;
        n_out.valid_res = 1'b0;
        n_out.address   = 32'd0;
        if (!r_in.empty_string && ok) begin
            n_out.valid_res = 1'b1;
            n_out.address   = {s_addr, s_octet_value[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octet_index <= 2'd0;
            r_digit_count <= 2'd0;
            r_octet_value <= 10'd0;
            r_zero_closed <= 1'b0;
            r_failed      <= 1'b0;
            r_addr        <= 24'd0;
        end else if (advance) begin
            if (emits) begin
                r_octet_index <= 2'd0;
                r_digit_count <= 2'd0;
                r_octet_value <= 10'd0;
                r_zero_closed <= 1'b0;
                r_failed      <= 1'b0;
                r_addr        <= 24'd0;
            end else begin
                r_octet_index <= s_octet_index;
                r_digit_count <= s_digit_count;
                r_octet_value <= s_octet_value;
                r_zero_closed <= s_zero_closed;
                r_failed      <= s_failed;
                r_addr        <= s_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emits) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emits) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.valid_res |-> r_out.address == 32'd0)
        else $error("invalid result with nonzero address");

    a_zero_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero_closed |-> r_digit_count == 2'd1 && r_octet_value == 10'd0)
        else $error("leading-zero flag inconsistent with octet state");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emits |=> r_octet_index == 2'd0 && r_digit_count == 2'd0 && !r_failed)
        else $error("parse state not cleared after string end");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("stalled input byte lost");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule
